// ===== hdl/qbsb_pkg.sv =====
// ============================================================================
// qbsb_pkg
// Shared constants and types for the quadratic B-spline basis evaluator.
// ============================================================================
package qbsb_pkg;
    localparam int MAX_BASIS   = 64;
    localparam int FRAC_BITS   = 16;
    localparam int IDX_W       = 6;
    localparam int PNT_W       = 18;
    localparam int CNT_W       = 7;
    localparam int VAL_W       = 17;
    // scaled point s = x*m, |s| <= 2^17 * 62
    localparam int S_W         = 25;
    // knot index counts, 0..m (m <= 62)
    localparam int K_W         = 7;

    typedef struct packed {
        logic                    vld;
        logic                    err;
        logic                    one;
        logic signed [S_W-1:0]   s;
        logic        [K_W-1:0]   ti;
        logic        [K_W-1:0]   ti1;
        logic        [K_W-1:0]   ti2;
        logic        [K_W-1:0]   ti3;
    } t_knot_stage;

    typedef struct packed {
        logic                    vld;
        logic                    err;
        logic                    one;
        logic signed [S_W-1:0]   ua;   // s - ti*F
        logic signed [S_W-1:0]   ub;   // ti3*F - s
        logic        [1:0]       ca;   // 2/(ti2-ti)
        logic        [1:0]       cb;   // 2/(ti3-ti1)
        logic signed [S_W-1:0]   na;   // degree-1 value, over F
        logic signed [S_W-1:0]   nb;
    } t_deg1_stage;

    // clamped knot position in spacing units
    function automatic logic [K_W-1:0] knot(input logic [K_W:0] j, input logic [K_W-1:0] m);
        logic [K_W:0] k;
        begin
            k = (j < 2) ? '0 : j - (K_W+1)'(2);
            if (k > {1'b0, m}) k = {1'b0, m};
            knot = k[K_W-1:0];
        end
    endfunction
endpackage

// ===== hdl/qbsb_knot.sv =====
// ============================================================================
// qbsb_knot
// Stage 1: scale point by knot span count (basis count minus 2) and look up the four knots.
// ============================================================================
module qbsb_knot (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_vld,
    input  logic [qbsb_pkg::IDX_W-1:0]    i_idx,
    input  logic signed [qbsb_pkg::PNT_W-1:0] i_pnt,
    input  logic [qbsb_pkg::CNT_W-1:0]    i_cnt,
    output qbsb_pkg::t_knot_stage         o_stg
);
    logic [qbsb_pkg::K_W-1:0] w_m;
    logic [qbsb_pkg::K_W:0]   w_j;
    qbsb_pkg::t_knot_stage    n_stg, r_stg;

    assign w_m = i_cnt - qbsb_pkg::K_W'(2);
    assign w_j = {2'b00, i_idx};

    // form scaled point and knots
    always_comb begin
        n_stg     = r_stg;
        n_stg.vld = i_vld;
        n_stg.err = {1'b0, i_idx} >= i_cnt;
        n_stg.one = (i_idx == '0) && (i_pnt <= 0);
        n_stg.s   = qbsb_pkg::S_W'(i_pnt * $signed({1'b0, w_m}));
        n_stg.ti  = qbsb_pkg::knot(w_j, w_m);
        n_stg.ti1 = qbsb_pkg::knot(w_j + 1'b1, w_m);
        n_stg.ti2 = qbsb_pkg::knot(w_j + 2'd2, w_m);
        n_stg.ti3 = qbsb_pkg::knot(w_j + 2'd3, w_m);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg.vld <= 1'b0;
        end else if (i_en) begin
            r_stg <= n_stg;
        end
    end

    assign o_stg = r_stg;
endmodule

// ===== hdl/qbsb_deg1.sv =====
// ============================================================================
// qbsb_deg1
// Stage 2: degree-0 tests and degree-1 values of bases i and i+1.
// ============================================================================
module qbsb_deg1 (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  qbsb_pkg::t_knot_stage i_stg,
    output qbsb_pkg::t_deg1_stage o_stg
);
    localparam int SW = qbsb_pkg::S_W;
    localparam int FB = qbsb_pkg::FRAC_BITS;
    logic signed [SW-1:0] w_a, w_b, w_c, w_d;
    logic w_p0, w_p1, w_p2;
    qbsb_pkg::t_deg1_stage n_stg, r_stg;

    // knots scaled by F
    assign w_a = SW'($signed({1'b0, i_stg.ti})  <<< FB);
    assign w_b = SW'($signed({1'b0, i_stg.ti1}) <<< FB);
    assign w_c = SW'($signed({1'b0, i_stg.ti2}) <<< FB);
    assign w_d = SW'($signed({1'b0, i_stg.ti3}) <<< FB);
    assign w_p0 = (w_a < i_stg.s) && (i_stg.s <= w_b);
    assign w_p1 = (w_b < i_stg.s) && (i_stg.s <= w_c);
    assign w_p2 = (w_c < i_stg.s) && (i_stg.s <= w_d);

    always_comb begin
        n_stg     = r_stg;
        n_stg.vld = i_stg.vld;
        n_stg.err = i_stg.err;
        n_stg.one = i_stg.one;
        n_stg.ua  = i_stg.s - w_a;
        n_stg.ub  = w_d - i_stg.s;
        n_stg.ca  = (i_stg.ti2 - i_stg.ti == 1) ? 2'd2 :
                    (i_stg.ti2 - i_stg.ti == 2) ? 2'd1 : 2'd0;
        n_stg.cb  = (i_stg.ti3 - i_stg.ti1 == 1) ? 2'd2 :
                    (i_stg.ti3 - i_stg.ti1 == 2) ? 2'd1 : 2'd0;
        n_stg.na  = '0;
        n_stg.nb  = '0;
        if (i_stg.ti1 != i_stg.ti && w_p0) n_stg.na = n_stg.na + (i_stg.s - w_a);
        if (i_stg.ti2 != i_stg.ti1 && w_p1) n_stg.na = n_stg.na + (w_c - i_stg.s);
        if (i_stg.ti2 != i_stg.ti1 && w_p1) n_stg.nb = n_stg.nb + (i_stg.s - w_b);
        if (i_stg.ti3 != i_stg.ti2 && w_p2) n_stg.nb = n_stg.nb + (w_d - i_stg.s);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg.vld <= 1'b0;
        end else if (i_en) begin
            r_stg <= n_stg;
        end
    end

    assign o_stg = r_stg;
endmodule

// ===== hdl/qbsb_deg2.sv =====
// ============================================================================
// qbsb_deg2
// Stages 3 and 4: degree-2 products, then sum, scale and truncate.
// ============================================================================
module qbsb_deg2 (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  qbsb_pkg::t_deg1_stage         i_stg,
    output logic                          o_vld,
    output logic [qbsb_pkg::VAL_W-1:0]    o_val,
    output logic                          o_err
);
    localparam int SW = qbsb_pkg::S_W;
    localparam int PW = 2 * SW;
    localparam int FB = qbsb_pkg::FRAC_BITS;
    logic                 r_vld3, r_err3, r_one3;
    logic signed [PW-1:0] r_pa, r_pb;
    logic signed [PW-1:0] n_pa, n_pb;
    logic signed [PW:0]   w_sum;
    logic                 r_vld4, r_err4;
    logic [qbsb_pkg::VAL_W-1:0] r_val4, n_val4;

    // multiply each degree-1 term by its factor and distance
    always_comb begin
        n_pa = '0;
        n_pb = '0;
        if (i_stg.ca != 0 && i_stg.na != 0)
            n_pa = (i_stg.ua * i_stg.na) <<< (i_stg.ca == 2'd2);
        if (i_stg.cb != 0 && i_stg.nb != 0)
            n_pb = (i_stg.ub * i_stg.nb) <<< (i_stg.cb == 2'd2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld3 <= 1'b0;
        end else if (i_en) begin
            r_vld3 <= i_stg.vld;
            r_err3 <= i_stg.err;
            r_one3 <= i_stg.one;
            r_pa   <= n_pa;
            r_pb   <= n_pb;
        end
    end

    // sum, clamp and divide by 2F
    assign w_sum = {r_pa[PW-1], r_pa} + {r_pb[PW-1], r_pb};
    always_comb begin
        priority if (r_err3) begin
            n_val4 = '0;
        end else if (r_one3) begin
            n_val4 = qbsb_pkg::VAL_W'(1 << FB);
        end else if (w_sum < 0) begin
            n_val4 = '0;
        end else begin
            n_val4 = w_sum[FB+1 +: qbsb_pkg::VAL_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld4 <= 1'b0;
        end else if (i_en) begin
            r_vld4 <= r_vld3;
            r_err4 <= r_err3;
            r_val4 <= n_val4;
        end
    end

    assign o_vld = r_vld4;
    assign o_val = r_val4;
    assign o_err = r_err4;

`ifndef NO_ASSERTIONS
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld4 && r_err4 |-> r_val4 == '0) else $error("error item with value");
    a_val_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld4 |-> r_val4 <= qbsb_pkg::VAL_W'(1 << FB)) else $error("value above one");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |=> $stable(r_val4) && $stable(r_vld4)) else $error("stage moved in stall");
`endif
endmodule

// ===== hdl/quadratic_bspline_basis_eval_core.sv =====
// Path: each transaction passes the knot, degree-1, product and output registers in order.
// Throughput: one transaction per cycle; the four-stage pipeline freezes as a
// whole when the result register is full and not taken.
// Reset: synchronous active low; clears all valid bits, basis_count returns to 3.
// ============================================================================
// quadratic_bspline_basis_eval_core
// Top level: streaming ports, configuration register and pipeline stages.
// ============================================================================
module quadratic_bspline_basis_eval_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // basis_index[5:0], point[23:6]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // basis_value[16:0], zero fill
    output logic        m_axis_tuser,  // index_error
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [6:0]  i_cfg_data
);
    logic [qbsb_pkg::CNT_W-1:0] r_cnt;
    logic w_en;
    qbsb_pkg::t_knot_stage w_k;
    qbsb_pkg::t_deg1_stage w_d;
    logic w_vld, w_err;
    logic [qbsb_pkg::VAL_W-1:0] w_val;

    // advance whenever the last stage is empty or being taken
    assign w_en          = !w_vld || m_axis_tready;
    assign s_axis_tready = w_en;
    assign o_cfg_ready   = 1'b1;

    // hold basis count, clamped to its legal range
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= qbsb_pkg::CNT_W'(3);
        end else if (i_cfg_valid) begin
            if (i_cfg_data < 3) r_cnt <= qbsb_pkg::CNT_W'(3);
            else if (i_cfg_data > qbsb_pkg::MAX_BASIS)
                r_cnt <= qbsb_pkg::CNT_W'(qbsb_pkg::MAX_BASIS);
            else r_cnt <= i_cfg_data;
        end
    end

    qbsb_knot u_knot (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_vld(s_axis_tvalid), .i_idx(s_axis_tdata[5:0]),
        .i_pnt($signed(s_axis_tdata[23:6])), .i_cnt(r_cnt), .o_stg(w_k)
    );
    qbsb_deg1 u_deg1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_stg(w_k), .o_stg(w_d)
    );
    qbsb_deg2 u_deg2 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_stg(w_d),
        .o_vld(w_vld), .o_val(w_val), .o_err(w_err)
    );

    assign m_axis_tvalid = w_vld;
    assign m_axis_tdata  = {7'b0, w_val};
    assign m_axis_tuser  = w_err;
endmodule
